// ===== design/rfpwct_pkg.sv =====
// rfpwct_pkg: shared constants and types for the pulse-width code transmitter
// no dependencies; imported by rfpwct_in_if and the top level
package rfpwct_pkg;

  localparam int CODE_BITS = 24;
  localparam int CODE_W    = 24;
  localparam int BIDX_W    = $clog2(CODE_BITS + 1);
  localparam int TICK_W    = 8;
  localparam int RPT_W     = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_SYNC_HIGH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_END  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIT_END   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT    = 3'd5;

  localparam logic [TICK_W-1:0] SYNC_HIGH_RST = 8'd4;
  localparam logic [TICK_W-1:0] SYNC_END_RST  = 8'd128;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd12;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd4;
  localparam logic [TICK_W-1:0] BIT_END_RST   = 8'd16;
  localparam logic [RPT_W-1:0]  REPEAT_RST    = 4'd5;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SYNC = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

endpackage

// ===== design/rfpwct_if.sv =====
// rfpwct_in_if / rfpwct_out_if: valid/ready channels for request and result beats
// depends on rfpwct_pkg
interface rfpwct_in_if;
  import rfpwct_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CODE_W-1:0] code_word;

  modport source (output valid, req_type, code_word, input ready);
  modport sink   (input valid, req_type, code_word, output ready);
endinterface

interface rfpwct_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic line_driven;
  logic busy_res;
  logic accepted;
  logic all_done;

  modport source (output valid, line_level, line_driven, busy_res, accepted, all_done,
                  input ready);
  modport sink   (input valid, line_level, line_driven, busy_res, accepted, all_done,
                  output ready);
endinterface

// ===== design/rf_pulse_width_code_transmitter.sv =====
// rf_pulse_width_code_transmitter: 24-bit pulse-width ook frame encoder, top level
// depends on rfpwct_pkg and the channel interfaces in rfpwct_if.sv
//
// usage:
//   in_ch carries request beats: a start beat (req_type 0) with a code word, or a
//   timer tick beat (req_type 1). a start is accepted only while idle, else rejected.
//   out_ch returns exactly one result beat per request beat: line level, line
//   driven, busy, start accepted and frame sequence done.
//   the apb port writes and reads the six timing and repeat registers at 4*i;
//   write them only while no transmission runs.
//   latency: a result beat is valid the cycle after its request beat is taken.
//   throughput: one beat per cycle; state and result are updated in one pass
//   between the request handshake and the result register.
//   a stalled receiver holds the result register; in_ch.ready drops until the
//   waiting result beat is taken, so nothing is lost.
//   reset: idle, internal level low, counters cleared, registers to their defaults,
//   no result pending.
module rf_pulse_width_code_transmitter (
  input  logic                          clk,
  input  logic                          rst,
  rfpwct_in_if.sink                     in_ch,
  rfpwct_out_if.source                  out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfpwct_pkg::ADDR_W-1:0] paddr,
  input  logic [rfpwct_pkg::DATA_W-1:0] pwdata,
  output logic [rfpwct_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import rfpwct_pkg::*;

  logic [TICK_W-1:0] sync_high_ticks;
  logic [TICK_W-1:0] sync_end_ticks;
  logic [TICK_W-1:0] one_high_ticks;
  logic [TICK_W-1:0] zero_high_ticks;
  logic [TICK_W-1:0] bit_end_ticks;
  logic [RPT_W-1:0]  repeat_count;

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [BIDX_W-1:0]   bit_index, bit_index_next;
  logic [CODE_BITS-1:0] code_store;
  logic [RPT_W-1:0]    repeats_left, repeats_left_next;
  logic                level, level_next;

  logic                out_valid;
  logic                line_level, line_driven, busy_res, accepted, all_done;
  logic                accepted_next, done_next;

  logic                in_beat;
  logic                cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [TICK_W:0]     count_inc;
  logic [BIDX_W-1:0]   bit_pos;
  logic                cur_bit;
  logic [TICK_W-1:0]   high_ticks;
  logic [BIDX_W-1:0]   bidx_step;
  logic [RPT_W-1:0]    rpt_dec;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_high_ticks <= SYNC_HIGH_RST;
      sync_end_ticks  <= SYNC_END_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      zero_high_ticks <= ZERO_HIGH_RST;
      bit_end_ticks   <= BIT_END_RST;
      repeat_count    <= REPEAT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SYNC_HIGH: sync_high_ticks <= pwdata[TICK_W-1:0];
        REG_SYNC_END:  sync_end_ticks  <= pwdata[TICK_W-1:0];
        REG_ONE_HIGH:  one_high_ticks  <= pwdata[TICK_W-1:0];
        REG_ZERO_HIGH: zero_high_ticks <= pwdata[TICK_W-1:0];
        REG_BIT_END:   bit_end_ticks   <= pwdata[TICK_W-1:0];
        REG_REPEAT:    repeat_count    <= pwdata[RPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC_HIGH: prdata = DATA_W'(sync_high_ticks);
      REG_SYNC_END:  prdata = DATA_W'(sync_end_ticks);
      REG_ONE_HIGH:  prdata = DATA_W'(one_high_ticks);
      REG_ZERO_HIGH: prdata = DATA_W'(zero_high_ticks);
      REG_BIT_END:   prdata = DATA_W'(bit_end_ticks);
      REG_REPEAT:    prdata = DATA_W'(repeat_count);
      default:       prdata = '0;
    endcase
  end

  // result register frees up when empty or being taken
  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign in_beat     = in_ch.valid & in_ch.ready;

  assign count_inc = {1'b0, tick_count} + 1'b1;
  assign bit_pos   = BIDX_W'(CODE_BITS - 1) - bit_index;
  assign cur_bit   = (bit_index < BIDX_W'(CODE_BITS)) ? code_store[bit_pos] : 1'b0;
  assign high_ticks = cur_bit ? one_high_ticks : zero_high_ticks;
  assign rpt_dec   = (repeats_left != '0) ? repeats_left - 1'b1 : repeats_left;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    repeats_left_next = repeats_left;
    level_next        = level;
    accepted_next     = 1'b0;
    done_next         = 1'b0;
    bidx_step         = bit_index;
    if (in_ch.req_type == REQ_START) begin
      if (phase == PH_IDLE) begin
        accepted_next     = 1'b1;
        repeats_left_next = (repeat_count != '0) ? repeat_count : RPT_W'(1);
        phase_next        = PH_SYNC;
        tick_count_next   = '0;
        bit_index_next    = '0;
        level_next        = 1'b1;
      end
    end else begin
      case (phase)
        PH_SYNC: begin
          if (count_inc > {1'b0, sync_end_ticks}) begin
            level_next      = 1'b1;
            phase_next      = PH_DATA;
            tick_count_next = '0;
            bit_index_next  = '0;
          end else begin
            if (count_inc > {1'b0, sync_high_ticks}) level_next = 1'b0;
            tick_count_next = count_inc[TICK_W-1:0];
          end
        end
        PH_DATA: begin
          if (count_inc > {1'b0, high_ticks}) level_next = 1'b0;
          if (count_inc > {1'b0, bit_end_ticks}) begin
            tick_count_next = '0;
            bidx_step       = bit_index + 1'b1;
            level_next      = 1'b1;
          end else begin
            tick_count_next = count_inc[TICK_W-1:0];
          end
          bit_index_next = bidx_step;
          if (bidx_step >= BIDX_W'(CODE_BITS)) begin
            bit_index_next    = '0;
            tick_count_next   = '0;
            repeats_left_next = rpt_dec;
            if (rpt_dec != '0) begin
              phase_next = PH_SYNC;
              level_next = 1'b1;
            end else begin
              phase_next = PH_IDLE;
              level_next = 1'b0;
              done_next  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      repeats_left <= '0;
      level        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_beat) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        bit_index    <= bit_index_next;
        repeats_left <= repeats_left_next;
        level        <= level_next;
        out_valid    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      if ((in_ch.req_type == REQ_START) && (phase == PH_IDLE)) begin
        code_store <= CODE_BITS'(in_ch.code_word);
      end
      line_level  <= (phase_next != PH_IDLE) ? level_next : 1'b0;
      line_driven <= (phase_next != PH_IDLE);
      busy_res    <= (phase_next != PH_IDLE);
      accepted    <= accepted_next;
      all_done    <= done_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.line_level  = line_level;
  assign out_ch.line_driven = line_driven;
  assign out_ch.busy_res    = busy_res;
  assign out_ch.accepted    = accepted;
  assign out_ch.all_done    = all_done;

endmodule
